// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions used by the checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The expression must never be true at a rising edge outside of reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// File: design/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg
// Shared constants and types of the heap sorter.
// ----------------------------------------------------------------------------
package isort_pkg;

	localparam int MAX_COUNT = 64;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = $clog2(MAX_COUNT);
	localparam int CNT_W     = $clog2(MAX_COUNT + 1);
	// Child indexes of a node can reach twice the store depth.
	localparam int IDX_W     = ADDR_W + 2;

	typedef enum logic [1:0] {
		WS_IN  = 2'd0,
		WS_VAL = 2'd1,
		WS_BIG = 2'd2,
		WS_RDA = 2'd3
	} wsel_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		wsel_t             wsel;
		logic              re;
		logic [ADDR_W-1:0] raddr_a;
		logic [ADDR_W-1:0] raddr_b;
		logic              ld_val_a;
		logic              ld_val_b;
		logic              ld_big;
		logic              pick_left;
		logic              cmp_big;
	} ctrl_t;

endpackage

// File: design/isort_ctrl.sv
// ----------------------------------------------------------------------------
// isort_ctrl
// Sequencer of the heap sorter: load, heap build, extraction and readout.
// ----------------------------------------------------------------------------
module isort_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            s_tlast,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic            m_tlast,
	output logic            m_tuser,
	input  logic            gt,
	output isort_pkg::ctrl_t ctl
);
	import isort_pkg::*;

	typedef enum logic [10:0] {
		ST_LOAD      = 11'b000_0000_0001,
		ST_START     = 11'b000_0000_0010,
		ST_BUILD     = 11'b000_0000_0100,
		ST_LDVAL     = 11'b000_0000_1000,
		ST_EXTR      = 11'b000_0001_0000,
		ST_EXSWAP    = 11'b000_0010_0000,
		ST_SIFT_RD   = 11'b000_0100_0000,
		ST_SIFT_CMP  = 11'b000_1000_0000,
		ST_SIFT_SWAP = 11'b001_0000_0000,
		ST_OUT_RD    = 11'b010_0000_0000,
		ST_OUT_HOLD  = 11'b100_0000_0000
	} state_t;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              drop_q, drop_d;
	logic [CNT_W-1:0]  len_q, len_d;
	logic [CNT_W-1:0]  j_q, j_d;
	logic [ADDR_W-1:0] pos_q, pos_d;
	logic [ADDR_W-1:0] bidx_q, bidx_d;
	logic              extract_q, extract_d;

	logic [IDX_W-1:0]  lc, rc, len_x;
	logic              lc_ok, rc_ok, full, s_acc;
	logic [CNT_W-1:0]  jm1, jp1;

	assign lc    = {1'b0, pos_q, 1'b1};
	assign rc    = lc + IDX_W'(1);
	assign len_x = IDX_W'(len_q);
	assign lc_ok = lc < len_x;
	assign rc_ok = rc < len_x;
	assign full  = count_q >= CNT_W'(MAX_COUNT);
	assign jm1   = j_q - CNT_W'(1);
	assign jp1   = j_q + CNT_W'(1);

	assign s_tready = state_q == ST_LOAD;
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = state_q == ST_OUT_HOLD;
	assign m_tlast  = jp1 == count_q;
	assign m_tuser  = drop_q;

	always_comb begin
		ctl       = '0;
		state_d   = state_q;
		count_d   = count_q;
		drop_d    = drop_q;
		len_d     = len_q;
		j_d       = j_q;
		pos_d     = pos_q;
		bidx_d    = bidx_q;
		extract_d = extract_q;
		unique case (state_q)
			ST_LOAD: begin
				ctl.waddr = count_q[ADDR_W-1:0];
				ctl.wsel  = WS_IN;
				if (s_acc) begin
					if (!full) begin
						ctl.we  = 1'b1;
						count_d = count_q + CNT_W'(1);
					end else begin
						drop_d = 1'b1;
					end
					if (s_tlast) begin
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				len_d     = count_q;
				j_d       = count_q >> 1;
				extract_d = 1'b0;
				state_d   = ST_BUILD;
			end
			ST_BUILD: begin
				if (j_q == '0) begin
					extract_d = 1'b1;
					j_d       = len_q;
					state_d   = ST_EXTR;
				end else begin
					ctl.re      = 1'b1;
					ctl.raddr_a = jm1[ADDR_W-1:0];
					pos_d       = jm1[ADDR_W-1:0];
					j_d         = jm1;
					state_d     = ST_LDVAL;
				end
			end
			ST_LDVAL: begin
				ctl.ld_val_a = 1'b1;
				state_d      = ST_SIFT_RD;
			end
			ST_EXTR: begin
				if (j_q <= CNT_W'(1)) begin
					j_d     = '0;
					state_d = ST_OUT_RD;
				end else begin
					ctl.re      = 1'b1;
					ctl.raddr_a = '0;
					ctl.raddr_b = jm1[ADDR_W-1:0];
					state_d     = ST_EXSWAP;
				end
			end
			ST_EXSWAP: begin
				// The root goes to the end; the old last entry is sifted from the root.
				ctl.we       = 1'b1;
				ctl.waddr    = jm1[ADDR_W-1:0];
				ctl.wsel     = WS_RDA;
				ctl.ld_val_b = 1'b1;
				pos_d        = '0;
				len_d        = jm1;
				j_d          = jm1;
				state_d      = ST_SIFT_RD;
			end
			ST_SIFT_RD: begin
				if (!lc_ok) begin
					ctl.we    = 1'b1;
					ctl.waddr = pos_q;
					ctl.wsel  = WS_VAL;
					state_d   = extract_q ? ST_EXTR : ST_BUILD;
				end else begin
					ctl.re      = 1'b1;
					ctl.raddr_a = lc[ADDR_W-1:0];
					ctl.raddr_b = rc[ADDR_W-1:0];
					state_d     = ST_SIFT_CMP;
				end
			end
			ST_SIFT_CMP: begin
				ctl.ld_big    = 1'b1;
				ctl.pick_left = !rc_ok || gt;
				bidx_d        = ctl.pick_left ? lc[ADDR_W-1:0] : rc[ADDR_W-1:0];
				state_d       = ST_SIFT_SWAP;
			end
			ST_SIFT_SWAP: begin
				// The sifted value stays in a register; only the hole moves down.
				ctl.cmp_big = 1'b1;
				ctl.we      = 1'b1;
				ctl.waddr   = pos_q;
				if (gt) begin
					ctl.wsel = WS_BIG;
					pos_d    = bidx_q;
					state_d  = ST_SIFT_RD;
				end else begin
					ctl.wsel = WS_VAL;
					state_d  = extract_q ? ST_EXTR : ST_BUILD;
				end
			end
			ST_OUT_RD: begin
				ctl.re      = 1'b1;
				ctl.raddr_a = j_q[ADDR_W-1:0];
				state_d     = ST_OUT_HOLD;
			end
			ST_OUT_HOLD: begin
				if (m_tready) begin
					if (m_tlast) begin
						count_d   = '0;
						drop_d    = 1'b0;
						extract_d = 1'b0;
						state_d   = ST_LOAD;
					end else begin
						j_d     = jp1;
						state_d = ST_OUT_RD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			drop_q    <= 1'b0;
			len_q     <= '0;
			j_q       <= '0;
			pos_q     <= '0;
			bidx_q    <= '0;
			extract_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			drop_q    <= drop_d;
			len_q     <= len_d;
			j_q       <= j_d;
			pos_q     <= pos_d;
			bidx_q    <= bidx_d;
			extract_q <= extract_d;
		end
	end

endmodule

// File: design/isort_dpath.sv
// ----------------------------------------------------------------------------
// isort_dpath
// Value store of the sorter with two registered read ports, the held value
// being sifted, and the single signed comparator shared by all steps.
// ----------------------------------------------------------------------------
module isort_dpath (
	input  logic                          clk,
	input  logic [isort_pkg::DATA_W-1:0]  in_data,
	input  isort_pkg::ctrl_t              ctl,
	output logic                          gt,
	output logic [isort_pkg::DATA_W-1:0]  out_data
);
	import isort_pkg::*;

	logic [DATA_W-1:0] mem [MAX_COUNT];
	logic [DATA_W-1:0] rd_a_q, rd_b_q;
	logic [DATA_W-1:0] val_q, big_q;
	logic [DATA_W-1:0] wdata, cmp_a, cmp_b;

	always_comb begin
		case (ctl.wsel)
			WS_IN:   wdata = in_data;
			WS_VAL:  wdata = val_q;
			WS_BIG:  wdata = big_q;
			WS_RDA:  wdata = rd_a_q;
			default: wdata = in_data;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= wdata;
		end
		if (ctl.re) begin
			rd_a_q <= mem[ctl.raddr_a];
			rd_b_q <= mem[ctl.raddr_b];
		end
	end

	// Either left child against right child, or larger child against held value.
	assign cmp_a = ctl.cmp_big ? big_q : rd_a_q;
	assign cmp_b = ctl.cmp_big ? val_q : rd_b_q;
	assign gt    = $signed(cmp_a) > $signed(cmp_b);

	always_ff @(posedge clk) begin
		if (ctl.ld_val_a) begin
			val_q <= rd_a_q;
		end else if (ctl.ld_val_b) begin
			val_q <= rd_b_q;
		end
		if (ctl.ld_big) begin
			big_q <= ctl.pick_left ? rd_a_q : rd_b_q;
		end
	end

	assign out_data = rd_a_q;

endmodule

// File: design/introsort_sorter.sv
// Load: one word per cycle while s_axis_tready is high; tlast closes the set.
// Sort: heap build and extraction run on one comparator and one two-read store;
// each sift level reads both children and lifts the larger if above the sifted value.
// Readout: each word is read from the store, then held in the read register until taken.
// The block takes no input from the set's last word until its last result leaves.
// Reset clears the sequencer, count and overflow flag; the store stays unset.
// ----------------------------------------------------------------------------
// introsort_sorter
// Collects signed 32-bit words, heap-sorts them and streams them out ascending.
// ----------------------------------------------------------------------------
module introsort_sorter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] value
	input  logic        s_axis_tlast,   // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
	output logic        m_axis_tlast,   // final_res
	output logic        m_axis_tuser    // [0] overflow
);
	import isort_pkg::*;

	ctrl_t ctl;
	logic  gt;

	isort_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tlast  (s_axis_tlast),
		.s_tready (s_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tlast  (m_axis_tlast),
		.m_tuser  (m_axis_tuser),
		.gt       (gt),
		.ctl      (ctl)
	);

	isort_dpath u_dpath (
		.clk      (clk),
		.in_data  (s_axis_tdata),
		.ctl      (ctl),
		.gt       (gt),
		.out_data (m_axis_tdata)
	);

endmodule

// File: design/isort_chk.sv
// ----------------------------------------------------------------------------
// isort_chk
// Port-level checks of the sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module isort_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);
	logic        s_acc, m_acc, m_stall;
	logic [33:0] m_word;

	assign s_acc   = s_axis_tvalid && s_axis_tready;
	assign m_acc   = m_axis_tvalid && m_axis_tready;
	assign m_stall = m_axis_tvalid && !m_axis_tready;
	assign m_word  = {m_axis_tuser, m_axis_tlast, m_axis_tdata};

	// Loading and readout never overlap.
	`ASSERT_NEVER(a_no_overlap, s_axis_tready && m_axis_tvalid, "load and readout overlap")
	// Closing a set stops the input side at once.
	`ASSERT_CLK(a_close_stalls, s_acc && s_axis_tlast |=> !s_axis_tready, "input open after last")
	// After the final word of a set no result is shown in the next cycle.
	`ASSERT_CLK(a_final_ends, m_acc && m_axis_tlast |=> !m_axis_tvalid, "result after final word")
	// A stalled result keeps its word.
	`ASSERT_CLK(a_hold_word, m_stall |=> m_axis_tvalid && $stable(m_word), "stalled result changed")

endmodule

bind introsort_sorter isort_chk u_isort_chk (.*);
